// ===== src/ipv4_lpm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the ipv4 stride-8 trie lookup
// no dependencies; used by the level cells and the top level
package ipv4_lpm_pkg;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    localparam logic [1:0] CFG_ROOT_NODE      = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_ENABLE = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_HOP    = 2'd2;

    localparam logic [31:0] NO_ROUTE = 32'hFFFF_FFFF;

    // one node table entry
    typedef struct packed {
        logic [7:0]  child;
        logic        valid;
        logic [31:0] hop;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // request as it travels down the row of level cells
    typedef struct packed {
        logic        valid;
        op_t         op;
        logic [31:0] addr;
        logic [7:0]  node;
        logic [31:0] hop;
        logic        found;
        logic [7:0]  wr_node;
        logic [7:0]  wr_slot;
        logic [7:0]  wr_child;
        logic        wr_valid;
        logic [31:0] wr_hop;
    } req_t;

endpackage

// ===== src/ipv4_lpm_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module ipv4_lpm_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/ipv4_lpm_level_cell.sv =====
`timescale 1ns / 1ps
// one trie level: its own copy of the node table plus one request register
// depends on ipv4_lpm_pkg and ipv4_lpm_ram
module ipv4_lpm_level_cell #(
    parameter int TABLE_NODES = 256,
    parameter int LEVEL       = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               advance,
    input  logic                               clear_en,
    input  logic [$clog2(TABLE_NODES)+8-1:0]   clear_addr,
    input  ipv4_lpm_pkg::req_t                 req_i,
    output ipv4_lpm_pkg::req_t                 req_o
);

    localparam int NODE_W = $clog2(TABLE_NODES);
    localparam int ADDR_W = NODE_W + 8;
    localparam int DEPTH  = TABLE_NODES * 256;
    localparam int SHIFT  = 24 - 8 * LEVEL;

    logic [7:0]                    key;
    logic                          wr_hit;
    logic                          we;
    logic [ADDR_W-1:0]             raddr;
    logic [ADDR_W-1:0]             waddr;
    ipv4_lpm_pkg::slot_t           wr_entry;
    logic [ipv4_lpm_pkg::SLOT_W-1:0] wdata;
    logic [ipv4_lpm_pkg::SLOT_W-1:0] rdata;
    ipv4_lpm_pkg::slot_t           entry;
    ipv4_lpm_pkg::req_t            req_reg;
    logic                          walk_active;

    assign key = req_i.addr[SHIFT +: 8];

    // writes reach this copy of the table in request order
    assign wr_hit = advance && req_i.valid && (req_i.op == ipv4_lpm_pkg::OP_WRITE)
                    && (int'(req_i.wr_node) < TABLE_NODES);
    assign we     = wr_hit || clear_en;

    assign wr_entry.child = req_i.wr_child;
    assign wr_entry.valid = req_i.wr_valid;
    assign wr_entry.hop   = req_i.wr_hop;

    assign waddr = clear_en ? clear_addr : {NODE_W'(req_i.wr_node), req_i.wr_slot};
    assign wdata = clear_en ? '0 : wr_entry;
    assign raddr = {NODE_W'(req_i.node), key};

    ipv4_lpm_ram #(
        .WIDTH(ipv4_lpm_pkg::SLOT_W),
        .DEPTH(DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (advance),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign entry = ipv4_lpm_pkg::slot_t'(rdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg.valid <= 1'b0;
        end else if (advance) begin
            req_reg <= req_i;
        end
    end

    // node 0 or a node past the table ends the walk
    assign walk_active = (req_reg.node != 8'd0) && (int'(req_reg.node) < TABLE_NODES);

    always_comb begin
        req_o = req_reg;
        if (req_reg.op == ipv4_lpm_pkg::OP_LOOKUP) begin
            if (walk_active && entry.valid) begin
                req_o.hop   = entry.hop;
                req_o.found = 1'b1;
            end
            req_o.node = walk_active ? entry.child : 8'd0;
        end
    end

endmodule

// ===== src/ipv4_lpm_trie_lookup.sv =====
`timescale 1ns / 1ps
// top level of the ipv4 stride-8 longest-prefix-match trie lookup
// depends on ipv4_lpm_pkg and ipv4_lpm_level_cell
//
// Takes one request per cycle while s_tready is high: a write of one table
// slot or a lookup of an address. Four level cells form a row; each holds
// its own copy of the node table and resolves one address byte. The edge
// that accepts a lookup loads the first level cell; the lookup then moves
// through the other level cells in turn and on into the output register,
// where the result shows. Writes pass down the row in order so every lookup
// sees exactly the writes accepted before it. Writes give no result. The
// whole row stalls while a result waits at the output. After reset a
// clearing pass zeroes all min(NODE_COUNT, 256)*256 entries (at most 65536)
// of all four copies at once with s_tready low; configuration writes are
// taken throughout. The user must write configuration only while no request
// is in flight; the block itself does not enforce this.
module ipv4_stride8_trie_lookup #(
    parameter int NODE_COUNT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // lookup_address[31:0], write_node[39:32], write_slot[47:40],
    // write_child[55:48], write_valid[56], write_hop[88:57], zero[95:89]
    input  logic [95:0] s_tdata,
    // opcode[0]
    input  logic [0:0]  s_tuser,
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    // resolved_hop[31:0]
    output logic [31:0] m_tdata,
    // route_found[0]
    output logic [0:0]  m_tuser
);

    localparam int TABLE_NODES = (NODE_COUNT < 256) ? NODE_COUNT : 256;
    localparam int ADDR_W      = $clog2(TABLE_NODES) + 8;
    localparam int DEPTH       = TABLE_NODES * 256;

    logic [7:0]  root_node_reg;
    logic        default_enable_reg;
    logic [31:0] default_hop_reg;

    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic              clear_last;

    logic        advance;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [31:0] m_hop_reg;
    logic [31:0] m_hop_next;
    logic        m_found_reg;
    logic        m_found_next;

    ipv4_lpm_pkg::req_t pipe [0:4];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_node_reg      <= 8'd0;
            default_enable_reg <= 1'b0;
            default_hop_reg    <= 32'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ipv4_lpm_pkg::CFG_ROOT_NODE:      root_node_reg      <= cfg_wdata[7:0];
                ipv4_lpm_pkg::CFG_DEFAULT_ENABLE: default_enable_reg <= cfg_wdata[0];
                ipv4_lpm_pkg::CFG_DEFAULT_HOP:    default_hop_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clearing pass over every table entry after reset
    assign clear_last = (clear_addr_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clear_busy_reg) begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_last) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // the whole row moves unless a result waits at the output
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance && !clear_busy_reg;

    always_comb begin
        pipe[0].valid    = s_tvalid && s_tready;
        pipe[0].op       = ipv4_lpm_pkg::op_t'(s_tuser[0]);
        pipe[0].addr     = s_tdata[31:0];
        pipe[0].node     = root_node_reg;
        pipe[0].hop      = ipv4_lpm_pkg::NO_ROUTE;
        pipe[0].found    = 1'b0;
        pipe[0].wr_node  = s_tdata[39:32];
        pipe[0].wr_slot  = s_tdata[47:40];
        pipe[0].wr_child = s_tdata[55:48];
        pipe[0].wr_valid = s_tdata[56];
        pipe[0].wr_hop   = s_tdata[88:57];
    end

    for (genvar i = 0; i < 4; i++) begin : g_level
        ipv4_lpm_level_cell #(
            .TABLE_NODES(TABLE_NODES),
            .LEVEL      (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .clear_en   (clear_busy_reg),
            .clear_addr (clear_addr_reg),
            .req_i      (pipe[i]),
            .req_o      (pipe[i+1])
        );
    end

    // default route when nothing matched
    always_comb begin
        m_tvalid_next = pipe[4].valid && (pipe[4].op == ipv4_lpm_pkg::OP_LOOKUP);
        m_hop_next    = pipe[4].hop;
        m_found_next  = pipe[4].found;
        if (!pipe[4].found) begin
            if (default_enable_reg) begin
                m_hop_next   = default_hop_reg;
                m_found_next = 1'b1;
            end else begin
                m_hop_next   = ipv4_lpm_pkg::NO_ROUTE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= m_tvalid_next;
            m_hop_reg    <= m_hop_next;
            m_found_reg  <= m_found_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_hop_reg;
    assign m_tuser[0] = m_found_reg;

    // no request is taken and no result shows while the table is cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> (!s_tready && !m_tvalid_reg))
        else $error("request or result during table clear");

    // the clearing pass ends only after the last entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clear_busy_reg) |-> ($past(clear_addr_reg) == ADDR_W'(DEPTH - 1)))
        else $error("table clear ended early");

    // a result without a route always carries the no-route hop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_found_reg) |-> (m_hop_reg == ipv4_lpm_pkg::NO_ROUTE))
        else $error("no-route result with a hop");

    // a result stalled at the output holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> ($stable(m_hop_reg) && $stable(m_found_reg)))
        else $error("stalled result changed");

endmodule
